[rtl/jset_pkg.sv]
// Shared types, constants and helpers for the Julia set escape test block.
package jset_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 24;
  localparam int QW         = COORD_BITS + FRAC_BITS;  // plane value width
  localparam int EW         = QW + 3;                  // headroom before saturation
  localparam int STEP_W     = FRAC_BITS + 1;
  localparam int ITER_W     = 10;
  localparam int LIM_W      = QW - 1;
  localparam int CFG_W      = QW;
  localparam int CFG_IDX_W  = 3;
  localparam int RED_W      = 8;

  // multiplier split: magnitudes cut into two halves of HW bits
  localparam int HW = (QW + 1) / 2;
  localparam int MW = 2 * HW;
  localparam int AW = 4 * HW;

  typedef logic signed [QW-1:0] q_t;
  typedef logic signed [EW-1:0] qe_t;

  localparam q_t QMAX = {1'b0, {(QW-1){1'b1}}};
  localparam q_t QMIN = {1'b1, {(QW-1){1'b0}}};

  localparam logic [COORD_BITS-1:0] CENTER_RST = COORD_BITS'(1000);
  localparam logic [STEP_W-1:0] STEP_RST =
    STEP_W'(((longint'(15) << FRAC_BITS) + longint'(5000)) / longint'(10000));
  localparam q_t C_REAL_RST =
    QW'(-(((longint'(8) << FRAC_BITS) + longint'(5)) / longint'(10)));
  localparam q_t C_IMAG_RST =
    QW'(((longint'(156) << FRAC_BITS) + longint'(500)) / longint'(1000));
  localparam logic [ITER_W-1:0] ITER_RST = ITER_W'(200);
  localparam logic [LIM_W-1:0]  LIM_RST  = LIM_W'(longint'(1000) << FRAC_BITS);
  localparam logic [RED_W-1:0]  RED_ON   = {RED_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER,
    REG_STEP,
    REG_C_REAL,
    REG_C_IMAG,
    REG_MAX_ITER,
    REG_ESC_LIMIT
  } cfg_reg_e;

  typedef struct packed {
    logic capture;    // latch pixel offsets from center
    logic map;        // scale offsets by the pixel step
    logic load_z;     // saturate mapped point into z
    logic mul_start;  // launch re*re, im*im, re*im
    logic update;     // z <= z*z + c
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic escaped;
  } dp_sts_t;

  function automatic q_t sat_q(qe_t v);
    q_t r;
    if (v > EW'(QMAX)) begin
      r = QMAX;
    end else if (v < EW'(QMIN)) begin
      r = QMIN;
    end else begin
      r = v[QW-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/julia_set_escape_test.sv]
// Top level of the Julia set escape test: configuration registers, controller, datapath.
//
// One pixel word per command. A word (pixel_x_i, pixel_y_i) is taken at a rising
// edge with start_i high and busy_o low. The pixel is mapped to the plane as
// pixel_step*(center - coord) in signed Q12.24, then z = z*z + c is iterated up
// to max_iter times with an escape test |z|^2 > escape_limit after each update.
// The result word is shown for exactly one cycle with done_o high: inside_res_o
// is 1 if the point never escaped, and red_level_o is 255 for inside, else 0.
// The receiver cannot stall, so capture the result on the done_o cycle.
// At most max_iter iterations are run, fewer on an early escape. busy_o is
// already low in the strobe cycle, so the next pixel can be taken at the edge
// that ends it. Each iteration is paced by the multiply round: re*re, im*im
// and re*im run on three multipliers in parallel, each building its 36x36
// product from four 18x18 partial products, one per cycle, plus accumulate
// and saturate. Products are truncated toward zero on the magnitude and
// saturate to the Q12.24 range, as do the mapped point and each new re and im.
// Configuration (cfg_we_i, cfg_idx_i, cfg_wdata_i) must be written only while
// busy_o is low; index 0 center, 1 pixel_step, 2 c_real, 3 c_imag, 4 max_iter,
// 5 escape_limit; bits above each register's width are dropped, other indexes
// are ignored. max_iter of 0 reports every point inside.
module julia_set_escape_test import jset_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [COORD_BITS-1:0] pixel_x_i,
  input  logic [COORD_BITS-1:0] pixel_y_i,
  output logic                  done_o,
  output logic                  inside_res_o,
  output logic [RED_W-1:0]      red_level_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i
);

  // configuration registers
  logic [COORD_BITS-1:0] center_q;
  logic [STEP_W-1:0]     step_q;
  q_t                    c_real_q;
  q_t                    c_imag_q;
  logic [ITER_W-1:0]     max_iter_q;
  logic [LIM_W-1:0]      esc_limit_q;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;
  logic    in_set;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q    <= CENTER_RST;
      step_q      <= STEP_RST;
      c_real_q    <= C_REAL_RST;
      c_imag_q    <= C_IMAG_RST;
      max_iter_q  <= ITER_RST;
      esc_limit_q <= LIM_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_CENTER:    center_q    <= cfg_wdata_i[COORD_BITS-1:0];
        REG_STEP:      step_q      <= cfg_wdata_i[STEP_W-1:0];
        REG_C_REAL:    c_real_q    <= q_t'(cfg_wdata_i[QW-1:0]);
        REG_C_IMAG:    c_imag_q    <= q_t'(cfg_wdata_i[QW-1:0]);
        REG_MAX_ITER:  max_iter_q  <= cfg_wdata_i[ITER_W-1:0];
        REG_ESC_LIMIT: esc_limit_q <= cfg_wdata_i[LIM_W-1:0];
        default: ;  // unused indexes: write dropped
      endcase
    end
  end

  jset_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .max_iter_i (max_iter_q),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd),
    .busy_o     (busy_o),
    .done_o     (done_o),
    .inside_o   (in_set)
  );

  jset_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .sts_o       (dp_sts),
    .pixel_x_i   (pixel_x_i),
    .pixel_y_i   (pixel_y_i),
    .center_i    (center_q),
    .step_i      (step_q),
    .c_real_i    (c_real_q),
    .c_imag_i    (c_imag_q),
    .esc_limit_i (esc_limit_q)
  );

  // result word: red channel is full on for inside points
  assign inside_res_o = in_set;
  assign red_level_o  = in_set ? RED_ON : '0;

endmodule

[rtl/jset_mul.sv]
// Multi-cycle saturating fixed-point multiplier, four half-width partial products.
module jset_mul import jset_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  q_t   a_i,
  input  q_t   b_i,
  output logic done_o,
  output q_t   res_o
);

  localparam logic [2:0] STEP_LAST_PP = 3'd3;
  localparam logic [2:0] STEP_FIN     = 3'd5;
  localparam int         TW           = AW - FRAC_BITS;

  logic          run_q;
  logic [2:0]    step_q;
  logic          done_q;
  logic          neg_q;
  logic [MW-1:0] ma_q, mb_q;
  logic [MW-1:0] pp_q;
  logic [1:0]    pidx_q;
  logic [AW-1:0] acc_q;
  q_t            res_q;

  logic [QW-1:0] mag_a, mag_b;
  logic [HW-1:0] opa, opb;
  logic [MW-1:0] pp_d;
  logic [AW-1:0] pp_sh;
  logic [TW-1:0] trunc;
  logic [QW-1:0] lim;
  logic [QW-1:0] sat_mag;
  q_t            res_d;

  assign mag_a = a_i[QW-1] ? ($unsigned(~a_i) + QW'(1)) : $unsigned(a_i);
  assign mag_b = b_i[QW-1] ? ($unsigned(~b_i) + QW'(1)) : $unsigned(b_i);

  // step 0: lo*lo, 1: hi*lo, 2: lo*hi, 3: hi*hi
  assign opa  = step_q[0] ? ma_q[MW-1:HW] : ma_q[HW-1:0];
  assign opb  = step_q[1] ? mb_q[MW-1:HW] : mb_q[HW-1:0];
  assign pp_d = opa * opb;

  always_comb begin
    unique case (pidx_q)
      2'd0:       pp_sh = AW'(pp_q);
      2'd1, 2'd2: pp_sh = AW'(pp_q) << HW;
      2'd3:       pp_sh = AW'(pp_q) << (2 * HW);
      default:    pp_sh = AW'(pp_q);
    endcase
  end

  // truncate toward zero, clamp magnitude, then reapply sign
  assign trunc   = acc_q[AW-1:FRAC_BITS];
  assign lim     = neg_q ? $unsigned(QMIN) : $unsigned(QMAX);
  assign sat_mag = (trunc > TW'(lim)) ? lim : trunc[QW-1:0];
  assign res_d   = neg_q ? q_t'(~sat_mag + QW'(1)) : q_t'(sat_mag);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= '0;
      end else if (run_q) begin
        step_q <= step_q + 3'd1;
        if (step_q == STEP_FIN) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= a_i[QW-1] ^ b_i[QW-1];
      ma_q  <= MW'(mag_a);
      mb_q  <= MW'(mag_b);
      acc_q <= '0;
    end else if (run_q) begin
      if (step_q <= STEP_LAST_PP) begin
        pp_q   <= pp_d;
        pidx_q <= step_q[1:0];
      end
      if (step_q >= 3'd1 && step_q <= STEP_LAST_PP + 3'd1) begin
        acc_q <= acc_q + pp_sh;
      end
      if (step_q == STEP_FIN) begin
        res_q <= res_d;
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

[rtl/jset_dp.sv]
// Datapath: pixel mapping, z registers, three multipliers, update and escape compare.
module jset_dp import jset_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dp_cmd_t               cmd_i,
  output dp_sts_t               sts_o,
  input  logic [COORD_BITS-1:0] pixel_x_i,
  input  logic [COORD_BITS-1:0] pixel_y_i,
  input  logic [COORD_BITS-1:0] center_i,
  input  logic [STEP_W-1:0]     step_i,
  input  q_t                    c_real_i,
  input  q_t                    c_imag_i,
  input  logic [LIM_W-1:0]      esc_limit_i
);

  logic signed [COORD_BITS:0] dx_q, dy_q;
  qe_t px_q, py_q;
  q_t  re_q, im_q;

  q_t  rr, ii, ri;
  logic done_rr, done_ii, done_ri;
  qe_t re_sum, im_sum;
  logic [QW-1:0] mag_sum;

  jset_mul u_mul_rr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (re_q),
    .b_i     (re_q),
    .done_o  (done_rr),
    .res_o   (rr)
  );

  jset_mul u_mul_ii (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (im_q),
    .b_i     (im_q),
    .done_o  (done_ii),
    .res_o   (ii)
  );

  jset_mul u_mul_ri (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (re_q),
    .b_i     (im_q),
    .done_o  (done_ri),
    .res_o   (ri)
  );

  always_comb begin
    re_sum = EW'(rr) - EW'(ii) + EW'(c_real_i);
    im_sum = (EW'(ri) <<< 1) + EW'(c_imag_i);
  end

  // squares are never negative, so the sum fits in QW unsigned bits
  assign mag_sum = $unsigned(rr) + $unsigned(ii);

  assign sts_o.mul_done = done_rr & done_ii & done_ri;
  assign sts_o.escaped  = mag_sum > QW'(esc_limit_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      dx_q <= $signed({1'b0, center_i}) - $signed({1'b0, pixel_x_i});
      dy_q <= $signed({1'b0, center_i}) - $signed({1'b0, pixel_y_i});
    end
    if (cmd_i.map) begin
      px_q <= dx_q * $signed({1'b0, step_i});
      py_q <= dy_q * $signed({1'b0, step_i});
    end
    if (cmd_i.load_z) begin
      re_q <= sat_q(px_q);
      im_q <= sat_q(py_q);
    end else if (cmd_i.update) begin
      re_q <= sat_q(re_sum);
      im_q <= sat_q(im_sum);
    end
  end

endmodule

[rtl/jset_ctrl.sv]
// Controller: sequences mapping, multiply rounds, iteration count and the result strobe.
module jset_ctrl import jset_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [ITER_W-1:0] max_iter_i,
  input  dp_sts_t           sts_i,
  output dp_cmd_t           cmd_o,
  output logic              busy_o,
  output logic              done_o,
  output logic              inside_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP,
    ST_LOAD,
    ST_MSTART,
    ST_MWAIT,
    ST_UPD
  } state_e;

  state_e            state_q;
  logic [ITER_W-1:0] iter_q;
  logic              first_q;
  logic              done_q;
  logic              inside_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      iter_q   <= '0;
      first_q  <= 1'b0;
      done_q   <= 1'b0;
      inside_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) state_q <= ST_MAP;
        end
        ST_MAP: begin
          state_q <= ST_LOAD;
        end
        ST_LOAD: begin
          iter_q  <= '0;
          first_q <= 1'b1;
          state_q <= ST_MSTART;
        end
        ST_MSTART: begin
          state_q <= ST_MWAIT;
        end
        ST_MWAIT: begin
          if (sts_i.mul_done) begin
            first_q <= 1'b0;
            // the mapped point itself is never tested for escape
            if (!first_q && sts_i.escaped) begin
              done_q   <= 1'b1;
              inside_q <= 1'b0;
              state_q  <= ST_IDLE;
            end else if (iter_q == max_iter_i) begin
              done_q   <= 1'b1;
              inside_q <= 1'b1;
              state_q  <= ST_IDLE;
            end else begin
              state_q <= ST_UPD;
            end
          end
        end
        ST_UPD: begin
          iter_q  <= iter_q + ITER_W'(1);
          state_q <= ST_MSTART;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o.capture   = (state_q == ST_IDLE) && start_i;
    cmd_o.map       = (state_q == ST_MAP);
    cmd_o.load_z    = (state_q == ST_LOAD);
    cmd_o.mul_start = (state_q == ST_MSTART);
    cmd_o.update    = (state_q == ST_UPD);
  end

  assign busy_o   = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign inside_o = inside_q;

`ifndef ASSERT_OFF
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == ST_IDLE)
    else $error("result strobe while controller not idle");

  a_done_from_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == ST_MWAIT))
    else $error("result strobe not preceded by a multiply round");

  a_mul_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mul_start |=> !sts_i.mul_done)
    else $error("multiplier finished in one cycle");

  a_escape_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MWAIT && sts_i.mul_done && sts_i.escaped && !first_q)
      |=> done_q && !inside_q)
    else $error("escape not reported as outside");
`endif

endmodule

[tb/julia_set_escape_test_test.sv]
// Self-checking testbench for julia_set_escape_test: pixel words against a fixed-point escape model.
module julia_set_escape_test_test import jset_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // Plane range of a Q12.24 value, kept as plain 64-bit numbers for the model.
  localparam longint Q_HI = (longint'(1) << (QW - 1)) - 1;
  localparam longint Q_LO = -(longint'(1) << (QW - 1));
  localparam int     COORD_MAX = (1 << COORD_BITS) - 1;
  // Each part of c up to about 1.2 in most random phases: that is where the set has structure.
  localparam int     C_SPAN = 20132659;
  localparam int     PHASES = 12;
  localparam int     PHASE_WORDS = 112;
  // Longest pixel at the widest iteration count, used as the quiet time at the end.
  localparam int     LINGER = 9 * 1023 + 20;
  // Indexes past the last register: writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(REG_ESC_LIMIT) + 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = '1;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start_i = 1'b0;
  logic                  busy_o;
  logic [COORD_BITS-1:0] pixel_x_i = '0;
  logic [COORD_BITS-1:0] pixel_y_i = '0;
  logic                  done_o;
  logic                  inside_res_o;
  logic [RED_W-1:0]      red_level_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_W-1:0]      cfg_wdata_i = '0;

  int gap_pct = 0;  // chance in percent that the sender skips a cycle

  typedef struct {
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    logic                  in_set;
    logic [RED_W-1:0]      red;
  } verdict_t;

  // Holds a copy of the registers, works out the verdict of every accepted pixel
  // and matches the result words against those verdicts in order.
  class pixel_verdict_board;
    logic [COORD_BITS-1:0] center;
    logic [STEP_W-1:0]     step;
    q_t                    c_re;
    q_t                    c_im;
    logic [ITER_W-1:0]     iter_cap;
    logic [LIM_W-1:0]      limit;
    verdict_t              pending[$];
    int unsigned           errors;

    function new();
      center   = COORD_BITS'(1000);
      step     = STEP_W'(25166);            // 0.0015
      c_re     = QW'(-13421773);            // -0.8
      c_im     = QW'(2617246);              // 0.156
      iter_cap = ITER_W'(200);
      limit    = LIM_W'(longint'(1000) << FRAC_BITS);
      errors   = 0;
    endfunction

    // Bits above each register's width are dropped; spare indexes do nothing.
    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_CENTER:    center   = data[COORD_BITS-1:0];
        REG_STEP:      step     = data[STEP_W-1:0];
        REG_C_REAL:    c_re     = data;
        REG_C_IMAG:    c_im     = data;
        REG_MAX_ITER:  iter_cap = data[ITER_W-1:0];
        REG_ESC_LIMIT: limit    = data[LIM_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clamp_q(longint v);
      if (v > Q_HI) return Q_HI;
      if (v < Q_LO) return Q_LO;
      return v;
    endfunction

    // Magnitude product cut down by FRAC_BITS (toward zero), sign restored,
    // clamped to the range of the sign it lands on.
    function longint fx_mul(longint a, longint b);
      logic        neg;
      logic [79:0] mag;
      logic [79:0] cap;
      neg = (a < 0) != (b < 0);
      mag = 80'(a < 0 ? -a : a) * 80'(b < 0 ? -b : b);
      mag = mag >> FRAC_BITS;
      cap = neg ? 80'(Q_HI) + 80'd1 : 80'(Q_HI);
      if (mag > cap) mag = cap;
      return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
    endfunction

    function longint to_plane(logic [COORD_BITS-1:0] p);
      return clamp_q((longint'(center) - longint'(p)) * longint'(step));
    endfunction

    function verdict_t escape_verdict(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py);
      verdict_t v;
      longint   re;
      longint   im;
      longint   rr;
      longint   ii;
      longint   ri;
      longint   k;
      re = to_plane(px);
      im = to_plane(py);
      v.px = px;
      v.py = py;
      v.in_set = 1'b1;
      for (k = 0; k < longint'(iter_cap); k++) begin
        rr = fx_mul(re, re);
        ii = fx_mul(im, im);
        ri = fx_mul(re, im);
        re = clamp_q(rr - ii + longint'(c_re));
        im = clamp_q(2 * ri + longint'(c_im));
        // escape test on the clamped squares of the new z, exact compare
        rr = fx_mul(re, re);
        ii = fx_mul(im, im);
        if (rr + ii > longint'(limit)) begin
          v.in_set = 1'b0;
          break;
        end
      end
      v.red = v.in_set ? {RED_W{1'b1}} : '0;
      return v;
    endfunction

    function void note_pixel(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py);
      pending.push_back(escape_verdict(px, py));
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
    endfunction

    function void check_result(logic got_in, logic [RED_W-1:0] got_red);
      verdict_t want;
      if (pending.size() == 0) begin
        flag($sformatf("result word (%0b,%0d) with no pixel outstanding", got_in, got_red));
        return;
      end
      want = pending.pop_front();
      if (got_in !== want.in_set)
        flag($sformatf("inside_res for pixel (%0d,%0d): want %0b got %0b",
                       want.px, want.py, want.in_set, got_in));
      if (got_red !== want.red)
        flag($sformatf("red_level for pixel (%0d,%0d): want %0d got %0d",
                       want.px, want.py, want.red, got_red));
    endfunction

    function void close_out();
      if (pending.size() != 0) begin
        flag($sformatf("%0d pixel(s) never answered", pending.size()));
        errors += pending.size() - 1;
      end
    endfunction
  endclass

  pixel_verdict_board board;

  julia_set_escape_test dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .pixel_x_i    (pixel_x_i),
    .pixel_y_i    (pixel_y_i),
    .done_o       (done_o),
    .inside_res_o (inside_res_o),
    .red_level_o  (red_level_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // The result strobe lasts one cycle and cannot be held off: take it at the
  // rising edge that closes that cycle.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) board.check_result(inside_res_o, red_level_o);
  end

  // All driver tasks start and end at a falling edge.

  // Random idle cycles first, then hold the pixel word until the block takes it.
  // start_i stays high on return so the next word can follow without a gap.
  task automatic send_pixel(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py);
    while ($urandom_range(99) < gap_pct) begin
      start_i = 1'b0;
      @(negedge clk_i);
    end
    start_i   = 1'b1;
    pixel_x_i = px;
    pixel_y_i = py;
    do @(posedge clk_i); while (busy_o);
    board.note_pixel(px, py);
    @(negedge clk_i);
  endtask

  // Stop sending, then wait for every outstanding verdict and for busy_o to drop.
  task automatic settle();
    start_i = 1'b0;
    do @(posedge clk_i); while (board.pending.size() != 0 || busy_o);
    @(negedge clk_i);
  endtask

  // Only called with the block idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    @(posedge clk_i);
    board.set_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic logic [COORD_BITS-1:0] clip_coord(int v);
    if (v < 0) return '0;
    if (v > COORD_MAX) return '1;
    return v[COORD_BITS-1:0];
  endfunction

  initial begin
    logic [CFG_W-1:0]      data;
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    int                    span;
    int                    off;

    board = new();
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // ---- directed part, back to back ----
    gap_pct = 0;
    // reset settings: the center pixel maps to z0 = 0, corners lie far out
    send_pixel(1000, 1000);
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(0, 4095);
    send_pixel(4095, 0);
    send_pixel(1000, 1001);
    send_pixel(1003, 998);
    send_pixel(12'hAAA, 12'h555);

    // zero iterations: every point inside, even far away ones
    settle();
    write_reg(REG_MAX_ITER, '0);
    send_pixel(0, 0);
    send_pixel(4095, 4095);

    // widest iteration count with c = 0: pixel (0,0) maps to z0 = 0, which never moves and runs the full count
    settle();
    write_reg(REG_MAX_ITER, CFG_W'(1023));
    write_reg(REG_C_REAL, '0);
    write_reg(REG_C_IMAG, '0);
    write_reg(REG_CENTER, '0);
    send_pixel(0, 0);
    send_pixel(4095, 4095);

    // zero escape limit: z = 0 stays inside, a z whose truncated squares are nonzero escapes at once
    settle();
    write_reg(REG_MAX_ITER, CFG_W'(5));
    write_reg(REG_ESC_LIMIT, '0);
    send_pixel(0, 0);
    send_pixel(0, 1);

    // extremes: c at both ends of the range, all-ones writes so the bits above
    // each register drop off, largest step so the mapped point saturates
    settle();
    write_reg(REG_C_REAL, CFG_W'(Q_LO));
    write_reg(REG_C_IMAG, CFG_W'(Q_HI));
    write_reg(REG_ESC_LIMIT, '1);
    write_reg(REG_STEP, '1);
    write_reg(REG_CENTER, '1);
    write_reg(REG_SPARE_LO, '0);
    write_reg(REG_SPARE_HI, '0);
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(0, 4095);

    // zero step: every pixel maps to the origin
    settle();
    write_reg(REG_STEP, '0);
    write_reg(REG_C_REAL, '0);
    write_reg(REG_C_IMAG, '0);
    send_pixel(123, 3210);

    // ---- random phases: new settings each phase, sender idling varies ----
    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      gap_pct = (phase % 3 == 0) ? 0 : (phase % 3 == 1) ? 74 : 12;

      // every write to a register narrower than the data word carries random bits above its width
      write_reg(REG_CENTER, CFG_W'({$urandom, $urandom}));

      data = CFG_W'({$urandom, $urandom});
      case ($urandom_range(3))
        0: data[STEP_W-1:0] = STEP_W'($urandom_range(400, 60000));
        1: data[STEP_W-1:0] = STEP_W'($urandom_range(1, 1 << FRAC_BITS));
        default: ;
      endcase
      write_reg(REG_STEP, data);

      if ($urandom_range(3) == 0) data = CFG_W'({$urandom, $urandom});
      else data = CFG_W'(longint'($urandom_range(0, 2 * C_SPAN)) - C_SPAN);
      write_reg(REG_C_REAL, data);
      if ($urandom_range(3) == 0) data = CFG_W'({$urandom, $urandom});
      else data = CFG_W'(longint'($urandom_range(0, 2 * C_SPAN)) - C_SPAN);
      write_reg(REG_C_IMAG, data);

      // short counts keep the run fast; one phase draws counts from 150 to 255, around the reset count
      data = CFG_W'({$urandom, $urandom});
      data[ITER_W-1:0] = (phase == 4) ? ITER_W'($urandom_range(150, 255))
                                      : ITER_W'($urandom_range(1, 40));
      write_reg(REG_MAX_ITER, data);

      data = CFG_W'({$urandom, $urandom});
      case ($urandom_range(2))
        0: data[LIM_W-1:0] = LIM_W'(longint'(4) << FRAC_BITS);
        1: data[LIM_W-1:0] = LIM_W'($urandom);
        default: ;
      endcase
      write_reg(REG_ESC_LIMIT, data);

      // most pixels land with each part of z0 within about 3 so both verdicts show up
      span = (board.step == 0) ? COORD_MAX
                               : int'((longint'(3) << FRAC_BITS) / board.step) + 1;
      if (span > COORD_MAX) span = COORD_MAX;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if ($urandom_range(9) < 7) begin
          off = $urandom_range(0, 2 * span);
          px  = clip_coord(int'(board.center) + off - span);
          off = $urandom_range(0, 2 * span);
          py  = clip_coord(int'(board.center) + off - span);
        end else begin
          px = COORD_BITS'($urandom);
          py = COORD_BITS'($urandom);
        end
        send_pixel(px, py);
      end
    end

    // drain, then give a stray result word time to show up
    settle();
    repeat (LINGER) @(posedge clk_i);
    board.close_out();
    if (board.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog, several times the slowest correct run.
  initial begin
    #40ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
